// ===== sv/krt_pkg.sv =====
`timescale 1ns / 1ps

package krt_pkg;

  // Default table depth.
  localparam int DEPTH_DEF = 64;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 7;
  localparam int LIMIT_W = 7;

  // Capacity limit after reset.
  localparam logic [LIMIT_W-1:0] CAP_RESET = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic shift;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic shift_go;
    logic shift_done;
  } sts_t;

endpackage

// ===== sv/krt_ctrl.sv =====
`timescale 1ns / 1ps

module krt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  krt_pkg::sts_t sts,
  output krt_pkg::ctrl_t ctl
);
  import krt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = sts.shift_go ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    ctl.load   = (state_r == S_IDLE) && start;
    ctl.scan   = (state_r == S_SCAN);
    ctl.decide = (state_r == S_DECIDE);
    ctl.shift  = (state_r == S_SHIFT);
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/krt_dpath.sv =====
`timescale 1ns / 1ps

module krt_dpath #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [krt_pkg::CMD_W-1:0]           in_command,
  input  logic signed [krt_pkg::KEY_W-1:0]    in_key,
  input  logic [krt_pkg::DATA_W-1:0]          in_data_in,
  input  logic                                cfg_wr_en,
  input  logic [krt_pkg::LIMIT_W-1:0]         cfg_wr_data,
  input  krt_pkg::ctrl_t                      ctl,
  output krt_pkg::sts_t                       sts,
  output logic                                out_valid,
  output logic [krt_pkg::STAT_W-1:0]          out_status,
  output logic [krt_pkg::POS_W-1:0]           out_position,
  output logic [krt_pkg::DATA_W-1:0]          out_data_out,
  output logic [krt_pkg::POS_W-1:0]           out_record_count
);
  import krt_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int RW  = KEY_W + DATA_W;

  // Record store: key in the upper half, data word in the lower half.
  logic [RW-1:0] mem [DEPTH];

  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  data_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [LIMIT_W-1:0] cap_r;
  logic [CW-1:0]      rd_ptr_r;
  logic               rd_valid_r;
  logic [AW-1:0]      rd_idx_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [DATA_W-1:0]  rd_data_r;
  logic               found_r;
  logic [AW-1:0]      match_idx_r;
  logic [DATA_W-1:0]  match_data_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [POS_W-1:0]   out_position_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [POS_W-1:0]   out_count_r;

  logic               mem_re;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [RW-1:0]      mem_wdata;

  logic               hit;
  logic               last;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      match_pos;
  logic [LW-1:0]      eff_limit;
  logic               full;

  logic [STAT_W-1:0]  dec_status;
  logic [CW-1:0]      dec_pos;
  logic [DATA_W-1:0]  dec_dout;
  logic [CW-1:0]      dec_count;
  logic               dec_we;
  logic [AW-1:0]      dec_waddr;
  logic [RW-1:0]      dec_wdata;
  logic [LW-1:0]      pos_wide;
  logic [LW-1:0]      count_wide;

  // Compare stage of the read pipeline.
  assign count_m1  = count_r - CW'(1);
  assign match_pos = CW'(match_idx_r) + CW'(1);
  assign hit       = rd_valid_r && (rd_key_r == key_r);
  assign last      = rd_valid_r && (CW'(rd_idx_r) == count_m1);
  assign mem_re    = (ctl.scan || ctl.shift) && (rd_ptr_r < count_r);

  assign sts.scan_done  = hit || last || (count_r == '0);
  assign sts.shift_go   = (cmd_r == CMD_DELETE) && found_r && (match_pos < count_r);
  assign sts.shift_done = last;

  // Effective limit saturates at the table depth.
  always_comb begin
    if (LW'(cap_r) > LW'(DEPTH)) begin
      eff_limit = LW'(DEPTH);
    end else begin
      eff_limit = LW'(cap_r);
    end
  end
  assign full = (LW'(count_r) >= eff_limit);

  // Result and table update for the latched command.
  always_comb begin
    dec_status = ST_DONE;
    dec_pos    = '0;
    dec_dout   = '0;
    dec_count  = count_r;
    dec_we     = 1'b0;
    dec_waddr  = match_idx_r;
    dec_wdata  = {key_r, data_r};
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (found_r) begin
          dec_status = ST_DUPLICATE;
        end else begin
          dec_we    = 1'b1;
          dec_waddr = count_r[AW-1:0];
          dec_count = count_r + CW'(1);
          dec_pos   = count_r + CW'(1);
          dec_dout  = data_r;
        end
      end
      CMD_SEARCH: begin
        if (found_r) begin
          dec_pos  = match_pos;
          dec_dout = match_data_r;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      CMD_MODIFY: begin
        if (found_r) begin
          dec_we   = 1'b1;
          dec_pos  = match_pos;
          dec_dout = data_r;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (found_r) begin
          dec_pos   = match_pos;
          dec_dout  = match_data_r;
          dec_count = count_m1;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  // Memory write port: the decide step or one shifted record per cycle.
  always_comb begin
    if (ctl.decide) begin
      mem_we    = dec_we;
      mem_waddr = dec_waddr;
      mem_wdata = dec_wdata;
    end else begin
      mem_we    = ctl.shift && rd_valid_r;
      mem_waddr = rd_idx_r - AW'(1);
      mem_wdata = {rd_key_r, rd_data_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      {rd_key_r, rd_data_r} <= mem[rd_ptr_r[AW-1:0]];
    end
  end

  // Record count. A delete that shifts commits the count when the shift ends.
  always_comb begin
    count_nxt = count_r;
    if (ctl.decide && !sts.shift_go) begin
      count_nxt = dec_count;
    end else if (ctl.shift && last) begin
      count_nxt = count_m1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      rd_ptr_r    <= '0;
      rd_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctl.decide;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (ctl.load) begin
        rd_ptr_r   <= '0;
        rd_valid_r <= 1'b0;
        found_r    <= 1'b0;
      end else if (ctl.decide) begin
        rd_ptr_r   <= match_pos;
        rd_valid_r <= 1'b0;
      end else if (ctl.scan || ctl.shift) begin
        rd_valid_r <= mem_re;
        if (mem_re) begin
          rd_ptr_r <= rd_ptr_r + CW'(1);
        end
        if (ctl.scan && hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Latched command word, read index and match capture.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      data_r <= in_data_in;
    end
    if (mem_re) begin
      rd_idx_r <= rd_ptr_r[AW-1:0];
    end
    if (ctl.scan && hit) begin
      match_idx_r  <= rd_idx_r;
      match_data_r <= rd_data_r;
    end
  end

  // Result register; positions and counts are reported in seven bits.
  assign pos_wide   = LW'(dec_pos);
  assign count_wide = LW'(dec_count);

  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      out_status_r   <= dec_status;
      out_position_r <= pos_wide[POS_W-1:0];
      out_data_r     <= dec_dout;
      out_count_r    <= count_wide[POS_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_position     = out_position_r;
  assign out_data_out     = out_data_r;
  assign out_record_count = out_count_r;

endmodule

// ===== sv/keyed_record_table_top.sv =====
`timescale 1ns / 1ps

// Keyed record table: a packed table of DEPTH records, each a 32-bit key and
// a 32-bit data word, driven by insert, search, modify and delete commands.
// A command word (in_command, in_key, in_data_in) is taken at a clock edge
// where start is high and busy is low. busy stays high while the command runs.
// Each command gives exactly one result word on out_status, out_position,
// out_data_out and out_record_count, shown for one cycle with out_valid high.
// The receiver cannot stall; the result is simply presented for that cycle.
// The key scan reads one record per cycle from the record memory. The result
// is registered in the decide step and shown in the cycle after it. A delete
// that must close the gap then moves later records down one place; busy
// covers that move. capacity_limit is written via cfg_wr_en / cfg_wr_data;
// the user must write it only while idle; the block does not enforce this.
// Synchronous reset (rst_n low) empties the table and sets the limit to 64;
// record contents are not cleared, as only stored records are ever read.
module keyed_record_table_top #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [krt_pkg::CMD_W-1:0]           in_command,
  input  logic signed [krt_pkg::KEY_W-1:0]    in_key,
  input  logic [krt_pkg::DATA_W-1:0]          in_data_in,
  input  logic                                cfg_wr_en,
  input  logic [krt_pkg::LIMIT_W-1:0]         cfg_wr_data,
  output logic                                out_valid,
  output logic [krt_pkg::STAT_W-1:0]          out_status,
  output logic [krt_pkg::POS_W-1:0]           out_position,
  output logic [krt_pkg::DATA_W-1:0]          out_data_out,
  output logic [krt_pkg::POS_W-1:0]           out_record_count
);
  import krt_pkg::*;

  ctrl_t ctl;
  sts_t  sts;

  // Sequencer for scan, decide and shift phases.
  krt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Record memory, compare pipeline and result register.
  krt_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_data_in       (in_data_in),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_position     (out_position),
    .out_data_out     (out_data_out),
    .out_record_count (out_record_count)
  );

endmodule

// ===== sv/krt_checker.sv =====
`timescale 1ns / 1ps

module krt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [krt_pkg::STAT_W-1:0]          out_status,
  input logic [krt_pkg::POS_W-1:0]           out_position,
  input logic [krt_pkg::DATA_W-1:0]          out_data_out
);
  import krt_pkg::*;

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  // Results are strobes: never two back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A failed command reports zero position and zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_position == '0 && out_data_out == '0))
    else $error("failed command reported a position or data");

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (.*);
